// File: design/mlbc_pkg.sv
`timescale 1ns / 1ps

package mlbc_pkg;

  // number of LEDs in the table (1 to 64)
  localparam int unsigned LED_COUNT = 8;
  localparam int unsigned LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  // level vector padded so that the low eight bits always exist
  localparam int unsigned LVL_EXT_W = (LED_COUNT > 8) ? LED_COUNT : 8;

  localparam logic [7:0] ALL_LEDS = 8'hFF;

  // command codes
  localparam logic [2:0] OP_BLINK_START = 3'd0;
  localparam logic [2:0] OP_BLINK_STOP  = 3'd1;
  localparam logic [2:0] OP_ON          = 3'd2;
  localparam logic [2:0] OP_OFF         = 3'd3;
  localparam logic [2:0] OP_TOGGLE      = 3'd4;
  localparam logic [2:0] OP_POLL        = 3'd5;

  // input word
  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  led_index;
    logic [31:0] on_time;
    logic [31:0] off_time;
    logic [31:0] systick;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [7:0] led_levels;
    logic       index_valid;
  } res_t;

endpackage

// File: design/multi_led_blink_controller_top.sv
`timescale 1ns / 1ps

// Multi-LED blink controller.
// A command word on cmd_i is taken at a rising edge where start is high and
// busy is low. Each command yields one result word on result_o, marked by a
// one-cycle done_o strobe; the receiver always takes it.
// One per-LED datapath (tick difference, saturating elapsed add, phase
// compare) is stepped by a small sequencer through DIFF, ACCUM and DECIDE
// for each LED polled. A bad index or unknown operation is answered from
// idle and busy never rises; start, stop, on, off and toggle pass through
// EXEC, and a poll of all LEDs steps through every entry in order.
// busy drops in the cycle the result is shown, so the next command may be
// taken while done_o is high.
// Reset clears every LED entry (durations, ticks, elapsed, first-poll flag)
// and turns every LED off; no result is pending after reset.
module multi_led_blink_controller_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mlbc_pkg::cmd_t      cmd_i,
  output logic                done_o,
  output mlbc_pkg::res_t      result_o
);

  localparam int unsigned LC  = mlbc_pkg::LED_COUNT;
  localparam int unsigned IW  = mlbc_pkg::LED_IDX_W;
  localparam int unsigned LEW = mlbc_pkg::LVL_EXT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DIFF   = 3'd2;
  localparam logic [2:0] S_ACCUM  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  localparam logic [IW-1:0] LAST_LED = IW'(LC - 1);

  // per-LED table
  logic [31:0]   on_ticks_q  [LC];
  logic [31:0]   off_ticks_q [LC];
  logic [31:0]   last_tick_q [LC];
  logic [31:0]   elapsed_q   [LC];
  logic [LC-1:0] first_poll_q;
  logic [LC-1:0] level_q;

  // sequencer and datapath registers
  logic [2:0]           state_q, state_d;
  logic [IW-1:0]        led_q, led_d;
  logic                 all_q, all_d;
  mlbc_pkg::cmd_t       cmd_q;
  logic [31:0]          diff_q, diff_d;
  logic                 back_q, back_d;
  logic [31:0]          sum_q, sum_d;
  logic                 done_q, done_d;
  mlbc_pkg::res_t       res_q, res_d;

  // table write port
  logic                 wr_en;
  logic [31:0]          wr_on, wr_off, wr_last, wr_elapsed;
  logic                 wr_first, wr_level;
  logic [LC-1:0]        level_d;
  logic [LEW-1:0]       level_ext;

  logic                 accept;
  logic                 idx_in_range;
  logic                 is_poll_all;
  logic                 cur_level;
  logic                 cur_stop_off;
  logic [31:0]          threshold;
  logic [31:0]          dur_next;
  logic                 flip;
  logic [32:0]          sum_full;
  logic                 finish;
  logic                 finish_ok;

  assign accept       = start && !busy;
  assign idx_in_range = {1'b0, cmd_i.led_index} < 9'(LC);
  assign is_poll_all  = (cmd_i.operation == mlbc_pkg::OP_POLL) &&
                        (cmd_i.led_index == mlbc_pkg::ALL_LEDS);

  // current entry fields
  assign cur_level    = level_q[led_q];
  assign cur_stop_off = (on_ticks_q[led_q] != 32'd0) && (off_ticks_q[led_q] != 32'd0);
  assign threshold    = cur_level ? on_ticks_q[led_q] : off_ticks_q[led_q];
  assign dur_next     = cur_level ? off_ticks_q[led_q] : on_ticks_q[led_q];
  assign flip         = (dur_next != 32'd0) && (first_poll_q[led_q] || (sum_q > threshold));

  // shared per-LED datapath
  assign sum_full = {1'b0, elapsed_q[led_q]} + {1'b0, diff_q};

  always_comb begin
    back_d = back_q;
    diff_d = diff_q;
    sum_d  = sum_q;
    if (state_q == S_DIFF) begin
      back_d = cmd_q.systick < last_tick_q[led_q];
      diff_d = cmd_q.systick - last_tick_q[led_q];
    end
    if (state_q == S_ACCUM) begin
      sum_d = sum_full[32] ? 32'hFFFF_FFFF : sum_full[31:0];
    end
  end

  // sequencer and write port control
  always_comb begin
    state_d    = state_q;
    led_d      = led_q;
    all_d      = all_q;
    finish     = 1'b0;
    finish_ok  = 1'b1;
    wr_en      = 1'b0;
    wr_on      = on_ticks_q[led_q];
    wr_off     = off_ticks_q[led_q];
    wr_last    = last_tick_q[led_q];
    wr_elapsed = elapsed_q[led_q];
    wr_first   = first_poll_q[led_q];
    wr_level   = cur_level;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          led_d = is_poll_all ? '0 : cmd_i.led_index[IW-1:0];
          all_d = is_poll_all;
          if (is_poll_all) begin
            state_d = S_DIFF;
          end else if (cmd_i.operation > mlbc_pkg::OP_POLL || !idx_in_range) begin
            finish    = 1'b1;
            finish_ok = 1'b0;
          end else if (cmd_i.operation == mlbc_pkg::OP_POLL) begin
            state_d = S_DIFF;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        wr_en      = 1'b1;
        wr_elapsed = 32'd0;
        if (cmd_q.operation == mlbc_pkg::OP_BLINK_START) begin
          wr_on    = cmd_q.on_time;
          wr_off   = cmd_q.off_time;
          wr_last  = cmd_q.systick;
          wr_first = 1'b1;
        end else begin
          // stop blinking first, then force the level
          wr_on    = 32'd0;
          wr_off   = 32'd0;
          wr_last  = 32'd0;
          wr_first = 1'b0;
          wr_level = cur_level && !cur_stop_off;
          unique case (cmd_q.operation)
            mlbc_pkg::OP_ON:     wr_level = 1'b1;
            mlbc_pkg::OP_OFF:    wr_level = 1'b0;
            mlbc_pkg::OP_TOGGLE: wr_level = !(cur_level && !cur_stop_off);
            default:             wr_level = cur_level && !cur_stop_off;
          endcase
        end
        state_d = S_IDLE;
        finish  = 1'b1;
      end
      S_DIFF: begin
        state_d = S_ACCUM;
      end
      S_ACCUM: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        wr_en   = 1'b1;
        wr_last = cmd_q.systick;
        if (back_q) begin
          // tick ran backwards: restart timing only
          wr_elapsed = 32'd0;
        end else begin
          wr_first   = 1'b0;
          wr_level   = cur_level ^ flip;
          wr_elapsed = flip ? 32'd0 : sum_q;
        end
        if (all_q && (led_q != LAST_LED)) begin
          led_d   = led_q + IW'(1);
          state_d = S_DIFF;
        end else begin
          state_d = S_IDLE;
          finish  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // level vector after this cycle's write
  always_comb begin
    level_d = level_q;
    if (wr_en) begin
      level_d[led_q] = wr_level;
    end
  end

  assign level_ext = LEW'(level_d);

  always_comb begin
    done_d = finish;
    res_d  = res_q;
    if (finish) begin
      res_d.led_levels  = level_ext[7:0];
      res_d.index_valid = finish_ok;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      led_q   <= '0;
      all_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      led_q   <= led_d;
      all_q   <= all_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    diff_q <= diff_d;
    back_q <= back_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  // LED table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LC; i++) begin
        on_ticks_q[i]  <= 32'd0;
        off_ticks_q[i] <= 32'd0;
        last_tick_q[i] <= 32'd0;
        elapsed_q[i]   <= 32'd0;
      end
      first_poll_q <= '0;
      level_q      <= '0;
    end else begin
      if (wr_en) begin
        on_ticks_q[led_q]   <= wr_on;
        off_ticks_q[led_q]  <= wr_off;
        last_tick_q[led_q]  <= wr_last;
        elapsed_q[led_q]    <= wr_elapsed;
        first_poll_q[led_q] <= wr_first;
      end
      level_q <= level_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // a result is never shown while a command is still being worked
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a result only follows an accepted command or finished work
  a_done_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(accept) || $past(busy))
    else $error("result strobe without a command");

  // poll of all LEDs walks the table in order
  a_walk_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && all_q && led_q != LAST_LED) |=>
      (state_q == S_DIFF && led_q == $past(led_q) + IW'(1)))
    else $error("poll walk out of order");

  // an out of range single command reports invalid
  a_bad_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_poll_all && !idx_in_range) |=> (done_o && !result_o.index_valid))
    else $error("bad index not reported");

endmodule
